// ===== src/smi_pkg.sv =====
// shared constants and types for the sliding median position filter
`timescale 1ns / 1ps
`default_nettype none

package smi_pkg;

   localparam int DEF_MAX_WINDOW  = 33;
   localparam int DEF_SAMPLE_BITS = 16;

   // register and result field widths
   localparam int LEN_BITS = 6;
   localparam int POS_BITS = 6;

   // window length arithmetic is done at this width, wide enough for any cap
   localparam int LEN_CALC_BITS = 7;

   localparam logic [LEN_CALC_BITS-1:0] LEN_CAP       = LEN_CALC_BITS'(32);
   localparam logic [LEN_CALC_BITS-1:0] LEN_OFF_LIMIT = LEN_CALC_BITS'(1);
   localparam logic [LEN_BITS-1:0]      LEN_RESET     = LEN_BITS'(5);

   // per-cycle command to the cell row
   typedef struct packed {
      logic load;    // take a new beat: shift the window, seed the ring
      logic count;   // compare the ring value, then rotate the ring
   } cell_ctrl_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_COUNT = 3'b010,
      ST_SCAN  = 3'b100
   } state_type;

endpackage : smi_pkg

`default_nettype wire

// ===== src/smi_cell.sv =====
// one window position: stored sample, ring value and its rank counters
`timescale 1ns / 1ps
`default_nettype none

module smi_cell
   import smi_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
   parameter int CNT_W       = 6
) (
   input  wire                           clock,
   input  wire                           reset,
   input  cell_ctrl_type                 ctrl,
   input  wire signed [SAMPLE_BITS-1:0]  shift_in,
   input  wire signed [SAMPLE_BITS-1:0]  ring_in,
   input  wire                           tag_in,
   input  wire                           tag_load,
   input  wire        [CNT_W-1:0]        half,
   output logic signed [SAMPLE_BITS-1:0] sample_out,
   output logic signed [SAMPLE_BITS-1:0] ring_out,
   output logic                          tag_out,
   output logic                          flag
);

   logic signed [SAMPLE_BITS-1:0] sample_ff;
   logic signed [SAMPLE_BITS-1:0] ring_ff;
   logic                          tag_ff;
   logic [CNT_W-1:0]              less_ff, less_in;
   logic [CNT_W-1:0]              le_ff, le_in;

   always_comb begin
      less_in = less_ff;
      le_in   = le_ff;
      if (ctrl.load) begin
         less_in = '0;
         le_in   = '0;
      end else if (ctrl.count && tag_ff) begin
         if (ring_ff < sample_ff) less_in = less_ff + CNT_W'(1);
         if (ring_ff <= sample_ff) le_in = le_ff + CNT_W'(1);
      end
   end

   // window sample shifts toward the oldest end on every beat
   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else if (ctrl.load) begin
         sample_ff <= shift_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         ring_ff <= shift_in;
         tag_ff  <= tag_load;
      end else if (ctrl.count) begin
         ring_ff <= ring_in;
         tag_ff  <= tag_in;
      end
      less_ff <= less_in;
      le_ff   <= le_in;
   end

   assign sample_out = sample_ff;
   assign ring_out   = ring_ff;
   assign tag_out    = tag_ff;
   assign flag       = (less_ff <= half) && (half < le_ff);

endmodule : smi_cell

`default_nettype wire

// ===== src/sliding_median_index.sv =====
// top level of the sliding median position filter: cell row and sequencer
`timescale 1ns / 1ps
`default_nettype none

// Sliding median position filter. Each sample beat shifts into a row of
// MAX_WINDOW cells (the delay line, cleared to zero by reset). The window is
// the newest N cells, N taken from requested_length: 1 or less turns the
// filter off (result 0), otherwise min(length, 32), plus one when the length
// is even, and never more than MAX_WINDOW. The result is the position, 0 being
// the oldest, of the element of sorted rank N/2; among equal values the
// oldest one wins. For each item the window is copied into a ring that
// rotates once around the cell row, one hop per cycle, while every cell
// counts the smaller and not-larger window values going past it, and the
// cells are then scanned from the oldest window position for the first one
// whose counts bracket rank N/2; the scan ends at the last window position at
// the latest. With the filter off the ring sweep is skipped.
// A finished result sits in an output register, so the next sample beat is
// taken while it waits on rsp_stall. requested_length should be written only
// while no item is in flight.

module sliding_median_index
   import smi_pkg::*;
#(
   parameter int MAX_WINDOW  = DEF_MAX_WINDOW,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire                          clock,
   input  wire                          reset,
   // sample channel
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire signed [SAMPLE_BITS-1:0] req_sample,
   // result channel
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output logic [POS_BITS-1:0]          rsp_median_position,
   // window length register
   input  wire                          csr_write_enable,
   input  wire [LEN_BITS-1:0]           csr_write_data
);

   localparam int CNT_W = $clog2(MAX_WINDOW + 1);   // holds 0..MAX_WINDOW
   localparam int IDX_W = $clog2(MAX_WINDOW);       // indexes a cell

   localparam logic [IDX_W-1:0] LAST_CELL = IDX_W'(MAX_WINDOW - 1);

   // window length register
   logic [LEN_BITS-1:0] requested_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         requested_length_ff <= LEN_RESET;
      end else if (csr_write_enable) begin
         requested_length_ff <= csr_write_data;
      end
   end

   // effective window size
   logic [LEN_CALC_BITS-1:0] len_ext, len_cap, len_odd, len_fit;
   logic [CNT_W-1:0]         win_n;
   logic [CNT_W-1:0]         half;
   logic [CNT_W-1:0]         base;

   always_comb begin
      len_ext = LEN_CALC_BITS'(requested_length_ff);
      len_cap = (len_ext > LEN_CAP) ? LEN_CAP : len_ext;
      // even requests grow by one
      len_odd = requested_length_ff[0] ? len_cap : len_cap + LEN_CALC_BITS'(1);
      len_fit = (len_odd > LEN_CALC_BITS'(MAX_WINDOW)) ?
                LEN_CALC_BITS'(MAX_WINDOW) : len_odd;
      // filter off for short requests
      win_n   = (len_ext <= LEN_OFF_LIMIT) ? '0 : len_fit[CNT_W-1:0];
   end

   assign half = win_n >> 1;
   assign base = CNT_W'(MAX_WINDOW) - win_n;

   // sequencer
   state_type      state_ff, state_in;
   logic [IDX_W-1:0] cyc_ff, cyc_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [POS_BITS-1:0] rsp_pos_ff, rsp_pos_in;

   logic             accept;
   logic             rsp_free;
   logic             hit;
   logic             load_rsp;
   logic [IDX_W-1:0] scan_cell;
   logic [MAX_WINDOW-1:0] flag;
   cell_ctrl_type    ctrl;

   assign accept    = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign scan_cell = IDX_W'(base + CNT_W'(scan_ff));

   // disabled filter answers at once; the last window position always ends the scan
   assign hit = (win_n == '0) || flag[scan_cell] ||
                (CNT_W'(scan_ff) == win_n - CNT_W'(1));
   assign load_rsp = (state_ff == ST_SCAN) && hit && rsp_free;

   assign ctrl.load  = accept;
   assign ctrl.count = (state_ff == ST_COUNT);

   always_comb begin
      state_in = state_ff;
      cyc_in   = cyc_ff;
      scan_in  = scan_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cyc_in   = '0;
               scan_in  = '0;
               state_in = (win_n == '0) ? ST_SCAN : ST_COUNT;
            end
         end
         ST_COUNT: begin
            // one full trip of the ring around the row
            if (cyc_ff == LAST_CELL) begin
               state_in = ST_SCAN;
            end else begin
               cyc_in = cyc_ff + IDX_W'(1);
            end
         end
         ST_SCAN: begin
            if (hit) begin
               // hold here while the previous result is still waiting
               if (rsp_free) state_in = ST_IDLE;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cyc_ff  <= cyc_in;
      scan_ff <= scan_in;
   end

   // output register
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);
   assign rsp_pos_in   = load_rsp ? ((win_n == '0) ? '0 : POS_BITS'(scan_ff)) : rsp_pos_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_pos_ff <= rsp_pos_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_median_position = rsp_pos_ff;

   // cell row: cell 0 oldest, the last cell takes the new beat
   logic signed [SAMPLE_BITS-1:0] cell_sample [MAX_WINDOW];
   logic signed [SAMPLE_BITS-1:0] cell_ring   [MAX_WINDOW];
   logic                          cell_tag    [MAX_WINDOW];

   for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
      localparam int NEXT = (k + 1) % MAX_WINDOW;

      logic signed [SAMPLE_BITS-1:0] shift_src;
      logic                          in_window;

      if (k == MAX_WINDOW - 1) begin : g_head
         assign shift_src = req_sample;
      end else begin : g_body
         assign shift_src = cell_sample[k + 1];
      end

      assign in_window = (CNT_W'(k) >= base);

      smi_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .CNT_W       (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .shift_in   (shift_src),
         .ring_in    (cell_ring[NEXT]),
         .tag_in     (cell_tag[NEXT]),
         .tag_load   (in_window),
         .half       (half),
         .sample_out (cell_sample[k]),
         .ring_out   (cell_ring[k]),
         .tag_out    (cell_tag[k]),
         .flag       (flag[k])
      );
   end

   // checks
   a_rsp_from_scan: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SCAN))
      else $error("result appeared without a finished scan");

   a_accept_starts_sweep: assert property (@(posedge clock) disable iff (reset)
      (accept && win_n != '0) |=> (state_ff == ST_COUNT && cyc_ff == '0))
      else $error("accepted beat did not start a ring sweep");

   a_full_sweep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COUNT && cyc_ff != LAST_CELL) |=> (state_ff == ST_COUNT))
      else $error("ring sweep ended early");

   a_disabled_zero: assert property (@(posedge clock) disable iff (reset)
      (load_rsp && win_n == '0) |=> (rsp_median_position == '0))
      else $error("disabled filter gave a nonzero position");

endmodule : sliding_median_index

`default_nettype wire

// ===== tb/tb_top.sv =====
// testbench for the sliding median position filter: stimulus, checking and run control
`timescale 1ns / 1ps

module tb_top;
   import smi_pkg::*;

   localparam int MAX_WINDOW   = DEF_MAX_WINDOW;
   localparam int SAMPLE_BITS  = DEF_SAMPLE_BITS;
   localparam int CLOCK_PERIOD = 10;

   // watchdog limit on the whole run, kept far above what a correct run needs
   localparam int CYCLE_LIMIT  = 400000;
   // quiet time watched for stray beats once every expected result is in
   localparam int DRAIN_CYCLES = 2 * MAX_WINDOW + 8;
   localparam int LONG_HOLD    = 400;

   localparam int PHASE_COUNT  = 14;
   localparam int PHASE_ITEMS  = 38;
   localparam int RANDOM_PHASE = 12;
   localparam int HOLD_PHASE   = 3;
   localparam int SPLIT_PHASE  = 6;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [POS_BITS-1:0]           position_type;

   // clock, reset and block inputs, all known from time zero
   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   sample_type          req_sample       = '0;
   logic                rsp_stall        = 1'b0;
   logic                csr_write_enable = 1'b0;
   logic [LEN_BITS-1:0] csr_write_data   = '0;

   wire                 req_stall;
   wire                 rsp_valid;
   wire  [POS_BITS-1:0] rsp_median_position;

   // samples waiting for the driver, and median positions waiting for the monitor
   sample_type   pending_samples[$];
   position_type expected_positions[$];

   // our own copy of the delay line and the length register
   sample_type          delay_line [MAX_WINDOW];
   logic [LEN_BITS-1:0] length_setting;

   int  samples_queued   = 0;
   int  samples_taken    = 0;
   int  results_checked  = 0;
   int  error_count      = 0;
   int  cycle_count      = 0;
   int  settings_written = 0;
   int  long_holds       = 0;

   // run control, set by the stimulus at the falling edge; the monitor clears the hold request
   bit  idle_enabled      = 1'b1;
   bit  long_hold_request = 1'b0;

   int  send_gap;
   int  stall_left;
   int  long_hold_left;
   position_type expected_pos;

   sliding_median_index DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_sample          (req_sample),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_median_position (rsp_median_position),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // effective window: 0 means the filter is off
   function automatic int window_length(input logic [LEN_BITS-1:0] requested);
      int n;
      if (requested <= LEN_OFF_LIMIT)
         return 0;
      n = (requested > LEN_CAP) ? int'(LEN_CAP) : int'(requested);
      // even requests grow by one, even past the cap
      if (!requested[0])
         n++;
      if (n > MAX_WINDOW)
         n = MAX_WINDOW;
      return n;
   endfunction

   // shift a sample into the delay line and rank the window; the first position
   // whose smaller and not-larger counts bracket rank n/2 is the oldest median
   function automatic position_type shift_and_find_median(input sample_type sample);
      int           n;
      int           base;
      int           half;
      int           below;
      int           not_above;
      bit           found;
      position_type pos;
      pos   = '0;
      found = 1'b0;
      for (int i = 0; i < MAX_WINDOW - 1; i++)
         delay_line[i] = delay_line[i + 1];
      delay_line[MAX_WINDOW - 1] = sample;
      n = window_length(length_setting);
      if (n != 0) begin
         base = MAX_WINDOW - n;
         half = n / 2;
         for (int i = 0; i < n; i++) begin
            below     = 0;
            not_above = 0;
            for (int j = 0; j < n; j++) begin
               if (delay_line[base + j] < delay_line[base + i])
                  below++;
               if (delay_line[base + j] <= delay_line[base + i])
                  not_above++;
            end
            if (!found && below <= half && half < not_above) begin
               pos   = POS_BITS'(i);
               found = 1'b1;
            end
         end
      end
      return pos;
   endfunction

   // mix of full-range values, clustered values that force ties, and the extremes
   function automatic sample_type random_sample();
      int v;
      case ($urandom_range(0, 3))
         0: v = int'($urandom_range(0, 6)) - 3;
         1: v = $urandom_range(0, 1) ? 32767 : -32768;
         2: v = int'($urandom_range(0, 200)) - 100;
         default: v = int'($urandom);
      endcase
      return SAMPLE_BITS'(v);
   endfunction

   task automatic queue_sample(input sample_type sample);
      pending_samples.push_back(sample);
      samples_queued++;
   endtask

   // sender holds until every sample is taken and every result has come back
   task automatic wait_for_drain();
      while (samples_taken != samples_queued || pending_samples.size() != 0
             || expected_positions.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_length(input logic [LEN_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      settings_written++;
   endtask

   // driver: one beat in flight, valid held until taken, random gaps between beats
   always @(posedge clock) begin
      if (reset) begin
         req_valid      <= 1'b0;
         send_gap       = 0;
         length_setting = LEN_RESET;
         for (int i = 0; i < MAX_WINDOW; i++)
            delay_line[i] = '0;
      end else begin
         // mirror the register write the block sees at this edge
         if (csr_write_enable)
            length_setting = csr_write_data;
         if (req_valid && !req_stall) begin
            expected_positions.push_back(shift_and_find_median(req_sample));
            samples_taken++;
         end
         // a stalled beat stays on the bus untouched
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
               req_valid  <= 1'b1;
               req_sample <= pending_samples.pop_front();
               if (idle_enabled && $urandom_range(0, 5) == 0)
                  send_gap = $urandom_range(1, 18);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result beat, drive receiver stall bursts and the long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall      <= 1'b0;
         stall_left     = 0;
         long_hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_positions.size() == 0) begin
               $error("median_position beat with nothing expected: actual %0d",
                      rsp_median_position);
               error_count++;
            end else begin
               expected_pos = expected_positions.pop_front();
               if (rsp_median_position !== expected_pos) begin
                  $error("median_position mismatch: expected %0d, actual %0d",
                         expected_pos, rsp_median_position);
                  error_count++;
               end
               results_checked++;
            end
         end
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_stall <= 1'b1;
         end else if (long_hold_request) begin
            // long hold-off so the output register fills and the input backs up
            long_hold_request = 1'b0;
            long_hold_left    = LONG_HOLD - 1;
            long_holds++;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (idle_enabled && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 18) - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("watchdog expired after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [LEN_BITS-1:0] phase_lengths [PHASE_COUNT];
      logic [LEN_BITS-1:0] length_now;

      // even requests, disabled settings, the cap and values past storage
      phase_lengths = '{6'd2, 6'd0, 6'd3, 6'd33, 6'd34, 6'd32, 6'd4,
                        6'd17, 6'd63, 6'd1, 6'd31, 6'd6, 6'd0, 6'd5};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset length of 5: extremes, sign boundary, ties against the zeroed line
      queue_sample(16'sh7fff);
      queue_sample(16'sh8000);
      queue_sample(16'sh0000);
      queue_sample(16'shffff);
      queue_sample(16'sh0001);
      queue_sample(16'sh7fff);
      queue_sample(16'sh7fff);
      queue_sample(16'sh8000);
      queue_sample(16'sh8000);
      queue_sample(16'sh5555);
      queue_sample(16'shaaaa);
      queue_sample(16'sh0000);
      wait_for_drain();

      // filter off: samples still shift into the line, result stays 0
      write_length(6'd1);
      queue_sample(16'sh0007);
      queue_sample(16'shfff9);
      queue_sample(16'sh0064);
      wait_for_drain();

      // all-ones request, window limited by the cap, with repeated values
      write_length(6'd63);
      queue_sample(16'sh0005);
      queue_sample(16'sh0005);
      queue_sample(16'sh0005);
      queue_sample(16'shfffe);
      queue_sample(16'sh8000);
      queue_sample(16'sh7fff);
      wait_for_drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         length_now = (p == RANDOM_PHASE) ? LEN_BITS'($urandom_range(0, 63))
                                          : phase_lengths[p];
         write_length(length_now);
         // quiet phases and the whole last phase run without idling
         idle_enabled = (p % 5 != 4) && (p != PHASE_COUNT - 1);
         if (p == HOLD_PHASE)
            long_hold_request = 1'b1;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            queue_sample(random_sample());
            // sender pauses mid-phase until the block has emptied out
            if (p == SPLIT_PHASE && k == PHASE_ITEMS / 2)
               wait_for_drain();
         end
         wait_for_drain();
      end

      // watch for stray beats after the last expected one
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_positions.size() != 0) begin
         $error("%0d median_position results never arrived", expected_positions.size());
         error_count++;
      end

      $display("covered %0d samples over %0d window length settings, %0d results checked",
               samples_taken, settings_written, results_checked);
      $display("receiver long hold-offs: %0d, cycles run: %0d, errors: %0d",
               long_holds, cycle_count, error_count);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule : tb_top
